// ===== src/wclm_pkg.sv =====
package wclm_pkg;

    // Face geometry
    localparam int GRID_CELLS = 256;
    localparam int CELL_W     = $clog2(GRID_CELLS);
    localparam int POS_W      = CELL_W + 1;

    // Face letters, first letter in the top byte
    localparam FACE_TEXT = {
        "ITLISOTWENTYRONETWOETENMTHIRTEENFIVEMELEVENIFOURTHREEPNINETEENSUFOURTEEN",
        "MIDNIGHTSIXTEENDEIGHTEENSEVENTEENOTWELVEHALFELQUARTEROTOPASTRONESATW",
        "OSIXTWELVETFOURAFIVESEVENMEIGHTENINETENTTHREECELEVENINOTHENAFTERNOON",
        "MORNINGSATENIGHTEVENINGCANDTCOLDCOOLETWARMURAHOT"
    };
    localparam int FACE_LEN = $bits(FACE_TEXT) / 8;

    // Time thresholds
    localparam int HALF_HOUR    = 30;
    localparam int DAY_HOURS    = 24;
    localparam int MORNING_FROM = 5;
    localparam int NOON         = 12;
    localparam int EVENING_FROM = 17;
    localparam int NIGHT_FROM   = 21;

    // Longest phrase: IT IS A QUARTER PAST ONE IN THE MORNING
    localparam int MAX_WORDS = 9;
    localparam int SLOT_W    = $clog2(MAX_WORDS);
    localparam int WLEN_W    = 4;
    localparam int WTEXT_W   = 8 * 9;

    typedef logic [5:0] word_id_t;

    // Number words carry their own value as code
    localparam word_id_t W_ONE       = 6'd1;
    localparam word_id_t W_TWO       = 6'd2;
    localparam word_id_t W_THREE     = 6'd3;
    localparam word_id_t W_FOUR      = 6'd4;
    localparam word_id_t W_FIVE      = 6'd5;
    localparam word_id_t W_SIX       = 6'd6;
    localparam word_id_t W_SEVEN     = 6'd7;
    localparam word_id_t W_EIGHT     = 6'd8;
    localparam word_id_t W_NINE      = 6'd9;
    localparam word_id_t W_TEN       = 6'd10;
    localparam word_id_t W_ELEVEN    = 6'd11;
    localparam word_id_t W_TWELVE    = 6'd12;
    localparam word_id_t W_THIRTEEN  = 6'd13;
    localparam word_id_t W_FOURTEEN  = 6'd14;
    localparam word_id_t W_FIFTEEN   = 6'd15;
    localparam word_id_t W_SIXTEEN   = 6'd16;
    localparam word_id_t W_SEVENTEEN = 6'd17;
    localparam word_id_t W_EIGHTEEN  = 6'd18;
    localparam word_id_t W_NINETEEN  = 6'd19;
    localparam word_id_t W_TWENTY    = 6'd20;
    localparam word_id_t W_HALF      = 6'd21;
    localparam word_id_t W_A         = 6'd22;
    localparam word_id_t W_QUARTER   = 6'd23;
    localparam word_id_t W_TO        = 6'd24;
    localparam word_id_t W_PAST      = 6'd25;
    localparam word_id_t W_MIDNIGHT  = 6'd26;
    localparam word_id_t W_IT        = 6'd27;
    localparam word_id_t W_IS        = 6'd28;
    localparam word_id_t W_AT        = 6'd29;
    localparam word_id_t W_NIGHT     = 6'd30;
    localparam word_id_t W_IN        = 6'd31;
    localparam word_id_t W_THE       = 6'd32;
    localparam word_id_t W_MORNING   = 6'd33;
    localparam word_id_t W_AFTERNOON = 6'd34;
    localparam word_id_t W_EVENING   = 6'd35;

    typedef struct packed {
        logic [WLEN_W-1:0]  len;
        logic [WTEXT_W-1:0] text;   // right-justified, first letter highest
    } word_rom_t;

    typedef struct packed {
        logic [SLOT_W-1:0]             count;
        word_id_t [MAX_WORDS-1:0]      ids;
    } phrase_t;

    function automatic word_rom_t word_rom(input word_id_t id);
        word_rom_t r;
        r.len  = '0;
        r.text = '0;
        case (id)
            W_ONE:       begin r.len = 4'd3; r.text = WTEXT_W'("ONE");       end
            W_TWO:       begin r.len = 4'd3; r.text = WTEXT_W'("TWO");       end
            W_THREE:     begin r.len = 4'd5; r.text = WTEXT_W'("THREE");     end
            W_FOUR:      begin r.len = 4'd4; r.text = WTEXT_W'("FOUR");      end
            W_FIVE:      begin r.len = 4'd4; r.text = WTEXT_W'("FIVE");      end
            W_SIX:       begin r.len = 4'd3; r.text = WTEXT_W'("SIX");       end
            W_SEVEN:     begin r.len = 4'd5; r.text = WTEXT_W'("SEVEN");     end
            W_EIGHT:     begin r.len = 4'd5; r.text = WTEXT_W'("EIGHT");     end
            W_NINE:      begin r.len = 4'd4; r.text = WTEXT_W'("NINE");      end
            W_TEN:       begin r.len = 4'd3; r.text = WTEXT_W'("TEN");       end
            W_ELEVEN:    begin r.len = 4'd6; r.text = WTEXT_W'("ELEVEN");    end
            W_TWELVE:    begin r.len = 4'd6; r.text = WTEXT_W'("TWELVE");    end
            W_THIRTEEN:  begin r.len = 4'd8; r.text = WTEXT_W'("THIRTEEN");  end
            W_FOURTEEN:  begin r.len = 4'd8; r.text = WTEXT_W'("FOURTEEN");  end
            W_FIFTEEN:   begin r.len = 4'd7; r.text = WTEXT_W'("FIFTEEN");   end
            W_SIXTEEN:   begin r.len = 4'd7; r.text = WTEXT_W'("SIXTEEN");   end
            W_SEVENTEEN: begin r.len = 4'd9; r.text = WTEXT_W'("SEVENTEEN"); end
            W_EIGHTEEN:  begin r.len = 4'd8; r.text = WTEXT_W'("EIGHTEEN");  end
            W_NINETEEN:  begin r.len = 4'd8; r.text = WTEXT_W'("NINETEEN");  end
            W_TWENTY:    begin r.len = 4'd6; r.text = WTEXT_W'("TWENTY");    end
            W_HALF:      begin r.len = 4'd4; r.text = WTEXT_W'("HALF");      end
            W_A:         begin r.len = 4'd1; r.text = WTEXT_W'("A");         end
            W_QUARTER:   begin r.len = 4'd7; r.text = WTEXT_W'("QUARTER");   end
            W_TO:        begin r.len = 4'd2; r.text = WTEXT_W'("TO");        end
            W_PAST:      begin r.len = 4'd4; r.text = WTEXT_W'("PAST");      end
            W_MIDNIGHT:  begin r.len = 4'd8; r.text = WTEXT_W'("MIDNIGHT");  end
            W_IT:        begin r.len = 4'd2; r.text = WTEXT_W'("IT");        end
            W_IS:        begin r.len = 4'd2; r.text = WTEXT_W'("IS");        end
            W_AT:        begin r.len = 4'd2; r.text = WTEXT_W'("AT");        end
            W_NIGHT:     begin r.len = 4'd5; r.text = WTEXT_W'("NIGHT");     end
            W_IN:        begin r.len = 4'd2; r.text = WTEXT_W'("IN");        end
            W_THE:       begin r.len = 4'd3; r.text = WTEXT_W'("THE");       end
            W_MORNING:   begin r.len = 4'd7; r.text = WTEXT_W'("MORNING");   end
            W_AFTERNOON: begin r.len = 4'd9; r.text = WTEXT_W'("AFTERNOON"); end
            W_EVENING:   begin r.len = 4'd7; r.text = WTEXT_W'("EVENING");   end
            default:     begin r.len = 4'd1; r.text = '0;                    end
        endcase
        return r;
    endfunction

    // Letter shown at one face position; past the end reads as zero
    function automatic logic [7:0] face_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < FACE_LEN; i++)
        begin
            if (pos == POS_W'(i))
            begin
                c = FACE_TEXT[8*(FACE_LEN-1-i) +: 8];
            end
        end
        return c;
    endfunction

endpackage

// ===== src/wclm_if.sv =====
interface wclm_time_if;
    import wclm_pkg::*;
    logic       valid;
    logic       ready;
    logic [4:0] hour;
    logic [5:0] minute;

    modport source (output valid, output hour, output minute, input ready);
    modport sink   (input valid, input hour, input minute, output ready);
endinterface

interface wclm_mask_if;
    import wclm_pkg::*;
    logic        valid;
    logic        ready;
    logic [63:0] mask_0;
    logic [63:0] mask_1;
    logic [63:0] mask_2;
    logic [63:0] mask_3;

    modport source (output valid, output mask_0, output mask_1, output mask_2,
                    output mask_3, input ready);
    modport sink   (input valid, input mask_0, input mask_1, input mask_2,
                    input mask_3, output ready);
endinterface

// ===== src/word_clock_letter_mask_top.sv =====
// Timing: the scan sequencer compares one face letter at a time, then lights the matched letters
// one at a time, with a start and a hand-off step; the walk crosses the face once.
// The single letter-compare unit in the scan sequencer sets how long a phrase takes.
// Throughput: one item at a time; the next is taken once the mask is handed on.
// Reset (rst_n, asynchronous, active low) returns both sequencers to idle.
module word_clock_letter_mask_top
    import wclm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    wclm_time_if.sink          clock_time,
    wclm_mask_if.source        letters
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_HOLD = 2'd2;

    logic [1:0]            st_reg, st_next;
    logic [GRID_CELLS-1:0] mask_reg, mask_next;
    phrase_t               phrase;
    logic                  start;
    logic                  scan_done;
    logic [GRID_CELLS-1:0] scan_mask;

    wclm_phrase u_phrase (
        .hour   (clock_time.hour),
        .minute (clock_time.minute),
        .phrase (phrase)
    );

    wclm_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .phrase (phrase),
        .done   (scan_done),
        .mask   (scan_mask)
    );

    assign clock_time.ready = st_reg == T_IDLE;
    assign start            = clock_time.valid && clock_time.ready;

    // Take an item, wait for the scan, hold the mask until taken
    always_comb
    begin
        st_next   = st_reg;
        mask_next = mask_reg;
        case (st_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    st_next = T_BUSY;
                end
            end
            T_BUSY:
            begin
                if (scan_done)
                begin
                    mask_next = scan_mask;
                    st_next   = T_HOLD;
                end
            end
            T_HOLD:
            begin
                if (letters.ready)
                begin
                    st_next = T_IDLE;
                end
            end
            default:
            begin
                st_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= T_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
    end

    assign letters.valid  = st_reg == T_HOLD;
    assign letters.mask_0 = mask_reg[63:0];
    assign letters.mask_1 = mask_reg[127:64];
    assign letters.mask_2 = mask_reg[191:128];
    assign letters.mask_3 = mask_reg[255:192];

endmodule

// ===== src/wclm_phrase.sv =====
module wclm_phrase
    import wclm_pkg::*;
(
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    output phrase_t    phrase
);

    logic             to_side;
    logic [5:0]       mins;
    logic [5:0]       hour_inc;
    logic [4:0]       hour_adj;
    logic [4:0]       hour_12;
    logic [SLOT_W-1:0] n;

    // Fold the minute and advance the hour on the TO side
    always_comb
    begin
        to_side  = minute > 6'(HALF_HOUR);
        mins     = minute;
        hour_inc = {1'b0, hour} + 6'd1;
        if (hour_inc >= 6'(DAY_HOURS))
        begin
            hour_inc = hour_inc - 6'(DAY_HOURS);
        end
        if (to_side)
        begin
            mins = (minute <= 6'd60) ? 6'd60 - minute : 6'd0;
        end
        hour_adj = (to_side && minute != 6'd0) ? hour_inc[4:0] : hour;
        if (hour_adj >= 5'(2 * NOON))
        begin
            hour_12 = hour_adj - 5'(2 * NOON);
        end
        else if (hour_adj >= 5'(NOON))
        begin
            hour_12 = hour_adj - 5'(NOON);
        end
        else
        begin
            hour_12 = hour_adj;
        end
    end

    // Build the ordered word list
    always_comb
    begin
        phrase.ids = {MAX_WORDS{W_IT}};
        n = '0;
        phrase.ids[n] = W_IT;   n = n + 1'b1;
        phrase.ids[n] = W_IS;   n = n + 1'b1;
        if (hour == 5'd0 && minute == 6'd0)
        begin
            phrase.ids[n] = W_MIDNIGHT; n = n + 1'b1;
        end
        else
        begin
            if (minute != 6'd0)
            begin
                if (mins == 6'(HALF_HOUR))
                begin
                    phrase.ids[n] = W_HALF; n = n + 1'b1;
                end
                else if (mins >= 6'd20)
                begin
                    phrase.ids[n] = W_TWENTY; n = n + 1'b1;
                    if (mins != 6'd20)
                    begin
                        // unit word: number code equals its value
                        phrase.ids[n] = word_id_t'(mins - 6'd20); n = n + 1'b1;
                    end
                end
                else if (mins == 6'd15)
                begin
                    phrase.ids[n] = W_A;       n = n + 1'b1;
                    phrase.ids[n] = W_QUARTER; n = n + 1'b1;
                end
                else if (mins != 6'd0)
                begin
                    phrase.ids[n] = word_id_t'(mins); n = n + 1'b1;
                end
                phrase.ids[n] = to_side ? W_TO : W_PAST; n = n + 1'b1;
            end
            phrase.ids[n] = (hour_12 == 5'd0) ? W_TWELVE : word_id_t'(hour_12);
            n = n + 1'b1;
            if (hour_adj < 5'(MORNING_FROM) || hour_adj >= 5'(NIGHT_FROM))
            begin
                phrase.ids[n] = W_AT;    n = n + 1'b1;
                phrase.ids[n] = W_NIGHT; n = n + 1'b1;
            end
            else
            begin
                phrase.ids[n] = W_IN;  n = n + 1'b1;
                phrase.ids[n] = W_THE; n = n + 1'b1;
                if (hour_adj < 5'(NOON))
                begin
                    phrase.ids[n] = W_MORNING;
                end
                else if (hour_adj < 5'(EVENING_FROM))
                begin
                    phrase.ids[n] = W_AFTERNOON;
                end
                else
                begin
                    phrase.ids[n] = W_EVENING;
                end
                n = n + 1'b1;
            end
        end
        phrase.count = n;
    end

endmodule

// ===== src/wclm_scan.sv =====
module wclm_scan
    import wclm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  phrase_t               phrase,
    output logic                  done,
    output logic [GRID_CELLS-1:0] mask
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_LIGHT  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]            st_reg, st_next;
    phrase_t               words_reg, words_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [WLEN_W-1:0]     ofs_reg, ofs_next;
    logic [GRID_CELLS-1:0] mask_reg, mask_next;

    word_rom_t             rom;
    logic [WLEN_W-1:0]     char_idx;
    logic [7:0]            word_c;
    logic [7:0]            face_c;
    logic [POS_W:0]        end_pos;
    logic [POS_W:0]        lit_pos;
    logic                  last_word;

    // Shared compare unit: one face letter against one word letter
    always_comb
    begin
        rom       = word_rom(words_reg.ids[slot_reg]);
        char_idx  = rom.len - 1'b1 - ofs_reg;
        word_c    = rom.text[{char_idx, 3'b000} +: 8];
        face_c    = face_char(pos_reg + POS_W'(ofs_reg));
        end_pos   = {1'b0, pos_reg} + (POS_W+1)'(rom.len);
        lit_pos   = {1'b0, pos_reg} + (POS_W+1)'(ofs_reg);
        last_word = slot_reg == words_reg.count - 1'b1;
    end

    // Sequencer: walk the face word by word, lighting each matched word before the next; a miss ends the walk
    always_comb
    begin
        st_next    = st_reg;
        words_next = words_reg;
        slot_next  = slot_reg;
        pos_next   = pos_reg;
        ofs_next   = ofs_reg;
        mask_next  = mask_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    words_next = phrase;
                    slot_next  = '0;
                    pos_next   = '0;
                    ofs_next   = '0;
                    mask_next  = '0;
                    st_next    = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (end_pos > (POS_W+1)'(FACE_LEN))
                begin
                    // word not on the face: stop here
                    st_next = S_DONE;
                end
                else if (face_c == word_c)
                begin
                    if (ofs_reg == rom.len - 1'b1)
                    begin
                        st_next = S_LIGHT;
                    end
                    else
                    begin
                        ofs_next = ofs_reg + 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    ofs_next = '0;
                end
            end
            S_LIGHT:
            begin
                if (lit_pos < (POS_W+1)'(GRID_CELLS))
                begin
                    mask_next[lit_pos[CELL_W-1:0]] = 1'b1;
                end
                if (ofs_reg == '0)
                begin
                    pos_next  = end_pos[POS_W-1:0];
                    slot_next = slot_reg + 1'b1;
                    st_next   = last_word ? S_DONE : S_SEARCH;
                end
                else
                begin
                    ofs_next = ofs_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        slot_reg  <= slot_next;
        pos_reg   <= pos_next;
        ofs_reg   <= ofs_next;
        mask_reg  <= mask_next;
    end

    assign done = st_reg == S_DONE;
    assign mask = mask_reg;

endmodule

// ===== bench/wclm_mask_checker.sv =====
module wclm_mask_checker
(
    input  logic  clk,
    input  logic  rst_n,
    wclm_time_if  time_ch,
    wclm_mask_if  mask_ch,
    output int    mismatches,
    output int    outstanding
);

    localparam int GRID          = 256;
    localparam int HALF_PAST     = 30;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int MORNING_START = 5;
    localparam int NOON_HOUR     = 12;
    localparam int EVENING_START = 17;
    localparam int NIGHT_START   = 21;

    typedef struct packed {
        logic [63:0] mask_0;
        logic [63:0] mask_1;
        logic [63:0] mask_2;
        logic [63:0] mask_3;
    } lit_mask_t;

    string          face_text;
    logic [GRID-1:0] lit_cells;
    int             scan_from;
    bit             scan_stopped;
    lit_mask_t      expected_letters [$];
    lit_mask_t      oldest;

    // Build the face, one line of letters at a time
    initial
    begin
        face_text = "ITLISOTWENTYRONETWOETENMTHIRTEENFIVEMELEVENIFOURTHREEPNINETEENSUFOURTEEN";
        face_text = {face_text, "MIDNIGHTSIXTEENDEIGHTEENSEVENTEENOTWELVEHALFELQUARTEROTOPASTRONESATW"};
        face_text = {face_text, "OSIXTWELVETFOURAFIVESEVENMEIGHTENINETENTTHREECELEVENINOTHENAFTERNOON"};
        face_text = {face_text, "MORNINGSATENIGHTEVENINGCANDTCOLDCOOLETWARMURAHOT"};
    end

    function string number_name(input int n);
        case (n)
            1:  return "ONE";
            2:  return "TWO";
            3:  return "THREE";
            4:  return "FOUR";
            5:  return "FIVE";
            6:  return "SIX";
            7:  return "SEVEN";
            8:  return "EIGHT";
            9:  return "NINE";
            10: return "TEN";
            11: return "ELEVEN";
            12: return "TWELVE";
            13: return "THIRTEEN";
            14: return "FOURTEEN";
            15: return "FIFTEEN";
            16: return "SIXTEEN";
            17: return "SEVENTEEN";
            18: return "EIGHTEEN";
            19: return "NINETEEN";
            default: return "";
        endcase
    endfunction

    // Find the word after the last match and light it; a miss stops all later words
    function void light_word(input string w);
        int  wl;
        int  p;
        int  j;
        bit  hit;
        wl = w.len();
        if (scan_stopped || wl == 0)
            return;
        for (p = scan_from; p + wl <= face_text.len(); p++)
        begin
            hit = 1'b1;
            for (j = 0; j < wl; j++)
            begin
                if (face_text[p + j] != w[j])
                    hit = 1'b0;
            end
            if (hit)
            begin
                for (j = 0; j < wl; j++)
                begin
                    if (p + j < GRID)
                        lit_cells[p + j] = 1'b1;
                end
                scan_from = p + wl;
                return;
            end
        end
        scan_stopped = 1'b1;
    endfunction

    // Spell the time out on the face and collect the lit cells
    function lit_mask_t predict_letters(input logic [4:0] hr, input logic [5:0] mn);
        int        h;
        int        m;
        bit        to_next;
        lit_mask_t r;
        lit_cells    = '0;
        scan_from    = 0;
        scan_stopped = 1'b0;
        h = hr;
        light_word("IT");
        light_word("IS");
        if (hr == 0 && mn == 0)
        begin
            light_word("MIDNIGHT");
        end
        else
        begin
            if (mn != 0)
            begin
                to_next = (mn > HALF_PAST);
                m = mn;
                if (to_next)
                    m = (mn <= MINS_PER_HOUR) ? MINS_PER_HOUR - mn : 0;
                if (m == HALF_PAST)
                begin
                    light_word("HALF");
                end
                else if (m >= 20)
                begin
                    light_word("TWENTY");
                    light_word(number_name(m % 10));
                end
                else if (m == 15)
                begin
                    light_word("A");
                    light_word("QUARTER");
                end
                else if (m >= 1)
                begin
                    light_word(number_name(m));
                end
                if (to_next)
                begin
                    light_word("TO");
                    h = (h + 1) % HOURS_PER_DAY;
                end
                else
                begin
                    light_word("PAST");
                end
            end
            if (h % 12 == 0)
                light_word("TWELVE");
            else
                light_word(number_name(h % 12));
            if (h < MORNING_START || h >= NIGHT_START)
            begin
                light_word("AT");
                light_word("NIGHT");
            end
            else
            begin
                light_word("IN");
                light_word("THE");
                if (h < NOON_HOUR)
                    light_word("MORNING");
                else if (h < EVENING_START)
                    light_word("AFTERNOON");
                else
                    light_word("EVENING");
            end
        end
        r.mask_0 = lit_cells[63:0];
        r.mask_1 = lit_cells[127:64];
        r.mask_2 = lit_cells[191:128];
        r.mask_3 = lit_cells[255:192];
        return r;
    endfunction

    task check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
        if (act !== exp)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
        end
    endtask

    // Queue a prediction per accepted time, compare each accepted mask with the oldest
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_letters.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (time_ch.valid && time_ch.ready)
                expected_letters.push_back(predict_letters(time_ch.hour, time_ch.minute));
            if (mask_ch.valid && mask_ch.ready)
            begin
                if (expected_letters.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: mask with no time pending, got %h %h %h %h", $time,
                             mask_ch.mask_3, mask_ch.mask_2, mask_ch.mask_1, mask_ch.mask_0);
                end
                else
                begin
                    oldest = expected_letters.pop_front();
                    check_field("mask_0", oldest.mask_0, mask_ch.mask_0);
                    check_field("mask_1", oldest.mask_1, mask_ch.mask_1);
                    check_field("mask_2", oldest.mask_2, mask_ch.mask_2);
                    check_field("mask_3", oldest.mask_3, mask_ch.mask_3);
                end
            end
            outstanding = expected_letters.size();
        end
    end

endmodule

// ===== bench/tb_word_clock_letter_mask_top.sv =====
module tb_word_clock_letter_mask_top;

    localparam int DIRECTED_N   = 25;
    localparam int PHASE_ITEMS  = 184;
    localparam int HOLD_CYCLES  = 4000;
    localparam int HOLD_ITEMS   = 4;
    localparam int SETTLE_WAIT  = 3000;
    localparam int IDLE_LIMIT   = 20000;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   stall_len;
    int   mismatches;
    int   outstanding;
    int   idle_cycles;

    // Directed times: midnight, noon, both ends of each field, every kind of minute phrase
    logic [4:0] dir_hour   [0:DIRECTED_N-1] = '{0, 0, 12, 23, 4, 11, 16, 20, 5, 17, 21, 8, 9,
                                                31, 24, 25, 0, 3, 6, 14, 19, 22, 10, 13, 7};
    logic [5:0] dir_minute [0:DIRECTED_N-1] = '{0, 1, 0, 59, 59, 45, 30, 31, 15, 20, 25, 13, 19,
                                                63, 60, 61, 30, 7, 10, 11, 12, 14, 16, 17, 18};

    wclm_time_if clock_time();
    wclm_mask_if letters();

    word_clock_letter_mask_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .clock_time (clock_time),
        .letters    (letters)
    );

    wclm_mask_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .time_ch     (clock_time),
        .mask_ch     (letters),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Offer one time, with random idle cycles first; return at the falling edge after acceptance
    task automatic send_time(input logic [4:0] hr, input logic [5:0] mn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            clock_time.valid <= 1'b0;
            @(negedge clk);
        end
        clock_time.valid  <= 1'b1;
        clock_time.hour   <= hr;
        clock_time.minute <= mn;
        do
            @(posedge clk);
        while (!clock_time.ready);
        @(negedge clk);
    endtask

    // Mostly valid times of day, with the odd out-of-range hour or minute
    task automatic send_random_time();
        int         sel;
        logic [4:0] hr;
        logic [5:0] mn;
        sel = $urandom_range(99);
        hr  = 5'($urandom_range(23));
        mn  = 6'($urandom_range(59));
        if (sel < 6)
        begin
            hr = 5'($urandom_range(31, 24));
            mn = 6'($urandom_range(63));
        end
        else if (sel < 12)
        begin
            mn = 6'($urandom_range(63, 60));
        end
        else if (sel < 16)
        begin
            hr = $urandom_range(1) ? 5'd0 : 5'd23;
            mn = $urandom_range(1) ? 6'd0 : 6'($urandom_range(59, 31));
        end
        send_time(hr, mn);
    endtask

    // Drive ready: long hold-off when asked, otherwise random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            letters.ready <= 1'b0;
        end
        else if (stall_len > 0)
        begin
            letters.ready <= 1'b0;
            stall_len = stall_len - 1;
        end
        else
        begin
            letters.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort when nothing moves on either channel for too long
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((clock_time.valid && clock_time.ready) || (letters.valid && letters.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_word_clock_letter_mask_top: done, errors");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        clock_time.valid  = 1'b0;
        clock_time.hour   = '0;
        clock_time.minute = '0;
        send_idle_pct     = 15;
        recv_idle_pct     = 65;
        stall_len         = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed times
        for (int i = 0; i < DIRECTED_N; i++)
            send_time(dir_hour[i], dir_minute[i]);

        // Pause the sender until the block has drained
        clock_time.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);

        // Hold the receiver off and keep offering, so the input backs up
        send_idle_pct = 0;
        stall_len     = HOLD_CYCLES;
        for (int i = 0; i < HOLD_ITEMS; i++)
            send_random_time();

        // Random times under three idle mixes
        send_idle_pct = 15;
        recv_idle_pct = 65;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_time();
        send_idle_pct = 65;
        recv_idle_pct = 15;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_time();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_time();

        // Drain, then watch a while longer for stray masks
        clock_time.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb_word_clock_letter_mask_top: done, clean");
        else
            $display("tb_word_clock_letter_mask_top: done, errors");
        $finish;
    end

endmodule
